// File: rtl/core/ncs_pkg.sv
package ncs_pkg;

    // table size
    localparam int MAX_CIRCLES_DEF = 16;
    localparam int SLOT_LIMIT      = 16;

    // opcodes
    localparam logic [2:0] OP_CREATE     = 3'd0;
    localparam logic [2:0] OP_SET_CENTER = 3'd1;
    localparam logic [2:0] OP_SET_RADIUS = 3'd2;
    localparam logic [2:0] OP_TRANSLATE  = 3'd3;
    localparam logic [2:0] OP_ROT_ORIGIN = 3'd4;
    localparam logic [2:0] OP_ROT_PIVOT  = 3'd5;
    localparam logic [2:0] OP_REMOVE     = 3'd6;

    // status codes
    localparam logic [2:0] STAT_OK         = 3'd0;
    localparam logic [2:0] STAT_OVERLAP    = 3'd1;
    localparam logic [2:0] STAT_NEG_RADIUS = 3'd2;
    localparam logic [2:0] STAT_FULL       = 3'd3;
    localparam logic [2:0] STAT_EMPTY      = 3'd4;

    // angle constants, Q16.16 degrees
    localparam logic [33:0]        DEG_FULL      = 34'd23592960;
    localparam logic [33:0]        DEG_OFFSET    = 34'd2170552320;
    localparam logic signed [25:0] DEG_FULL_S    = 26'sd23592960;
    localparam logic signed [25:0] DEG_HALF_S    = 26'sd11796480;
    localparam logic signed [25:0] DEG_QUARTER_S = 26'sd5898240;
    localparam logic [3:0]         CORDIC_LAST   = 4'd15;
    localparam logic signed [31:0] CORDIC_K_Q28  = 32'sd163008219;
    localparam logic signed [65:0] ROUND_HALF    = 66'sd134217728;

    localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

    typedef struct packed {
        logic [2:0]         opcode;
        logic [3:0]         slot;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] radius_in;
        logic signed [31:0] angle_deg;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot_out;
        logic signed [31:0] center_x_out;
        logic signed [31:0] center_y_out;
        logic [30:0]        radius_out;
    } rsp_t;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_LOAD, S_RED, S_FOLD, S_CORDIC, S_RMUL, S_RACC,
        S_RFIN, S_SCAN, S_DIF, S_SQX, S_SQY, S_SQR, S_CMP, S_FIN
    } ctrl_state_t;

    typedef enum logic [4:0] {
        CMD_IDLE, CMD_LATCH, CMD_SET_CREATE, CMD_RD_SLOT, CMD_LOAD_ENT, CMD_RED,
        CMD_FOLD, CMD_CORDIC, CMD_RMUL, CMD_RACC, CMD_RFIN, CMD_SCAN_NEXT,
        CMD_SCAN_RD, CMD_DIF, CMD_SQX, CMD_SQY, CMD_SQR, CMD_FINISH
    } dp_cmd_t;

    typedef enum logic [2:0] {
        RES_NEG, RES_FULL, RES_OVERLAP, RES_EMPTY, RES_REMOVE, RES_REPORT, RES_COMMIT
    } res_kind_t;

    typedef struct packed {
        dp_cmd_t   cmd;
        res_kind_t kind;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       rad_neg;
        logic       free_found;
        logic       slot_ok;
        logic       red_last;
        logic       cordic_last;
        logic       racc_fin;
        logic       rot_done;
        logic       scan_end;
        logic       scan_skip;
        logic       hit;
        logic       out_free;
    } dp_stat_t;

    // arctangent table in Q16.16 degrees
    function automatic logic signed [25:0] atan_deg(input logic [3:0] i);
        logic signed [25:0] r;
        case (i)
            4'd0:    r = 26'sd2949120;
            4'd1:    r = 26'sd1740967;
            4'd2:    r = 26'sd919879;
            4'd3:    r = 26'sd466945;
            4'd4:    r = 26'sd234379;
            4'd5:    r = 26'sd117305;
            4'd6:    r = 26'sd58666;
            4'd7:    r = 26'sd29335;
            4'd8:    r = 26'sd14668;
            4'd9:    r = 26'sd7334;
            4'd10:   r = 26'sd3667;
            4'd11:   r = 26'sd1833;
            4'd12:   r = 26'sd917;
            4'd13:   r = 26'sd458;
            4'd14:   r = 26'sd229;
            default: r = 26'sd115;
        endcase
        return r;
    endfunction

    // clamp to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7FFFFFFF;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/core/ncs_ctrl.sv
module ncs_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  ncs_pkg::dp_stat_t stat,
    output ncs_pkg::dp_ctrl_t ctrl
);
    import ncs_pkg::*;

    ctrl_state_t state_reg, state_next;
    res_kind_t   kind_reg, kind_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            kind_reg  <= RES_REPORT;
        end
        else
        begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        kind_next  = kind_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (stat.op == OP_CREATE)
                begin
                    if (stat.rad_neg)
                    begin
                        state_next = S_FIN;
                        kind_next  = RES_NEG;
                    end
                    else if (!stat.free_found)
                    begin
                        state_next = S_FIN;
                        kind_next  = RES_FULL;
                    end
                    else
                        state_next = S_SCAN;
                end
                else if (!stat.slot_ok)
                begin
                    state_next = S_FIN;
                    kind_next  = RES_EMPTY;
                end
                else
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                case (stat.op)
                    OP_SET_CENTER, OP_TRANSLATE:
                        state_next = S_SCAN;
                    OP_SET_RADIUS:
                    begin
                        if (stat.rad_neg)
                        begin
                            state_next = S_FIN;
                            kind_next  = RES_NEG;
                        end
                        else
                            state_next = S_SCAN;
                    end
                    OP_ROT_ORIGIN, OP_ROT_PIVOT:
                        state_next = S_RED;
                    OP_REMOVE:
                    begin
                        state_next = S_FIN;
                        kind_next  = RES_REMOVE;
                    end
                    default:
                    begin
                        state_next = S_FIN;
                        kind_next  = RES_REPORT;
                    end
                endcase
            end
            S_RED:
            begin
                if (stat.red_last)
                    state_next = S_FOLD;
            end
            S_FOLD:
                state_next = S_CORDIC;
            S_CORDIC:
            begin
                if (stat.cordic_last)
                    state_next = S_RMUL;
            end
            S_RMUL:
                state_next = S_RACC;
            S_RACC:
                state_next = stat.racc_fin ? S_RFIN : S_RMUL;
            S_RFIN:
                state_next = stat.rot_done ? S_SCAN : S_RMUL;
            S_SCAN:
            begin
                if (stat.scan_end)
                begin
                    state_next = S_FIN;
                    kind_next  = RES_COMMIT;
                end
                else if (!stat.scan_skip)
                    state_next = S_DIF;
            end
            S_DIF:
                state_next = S_SQX;
            S_SQX:
                state_next = S_SQY;
            S_SQY:
                state_next = S_SQR;
            S_SQR:
                state_next = S_CMP;
            S_CMP:
            begin
                if (stat.hit)
                begin
                    state_next = S_FIN;
                    kind_next  = RES_OVERLAP;
                end
                else
                    state_next = S_SCAN;
            end
            S_FIN:
            begin
                if (stat.out_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // datapath commands
    always_comb
    begin
        ctrl.cmd  = CMD_IDLE;
        ctrl.kind = kind_reg;
        req_stall = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    ctrl.cmd = CMD_LATCH;
            end
            S_DECODE:
            begin
                if (stat.op == OP_CREATE)
                begin
                    if (!stat.rad_neg && stat.free_found)
                        ctrl.cmd = CMD_SET_CREATE;
                end
                else if (stat.slot_ok)
                    ctrl.cmd = CMD_RD_SLOT;
            end
            S_LOAD:   ctrl.cmd = CMD_LOAD_ENT;
            S_RED:    ctrl.cmd = CMD_RED;
            S_FOLD:   ctrl.cmd = CMD_FOLD;
            S_CORDIC: ctrl.cmd = CMD_CORDIC;
            S_RMUL:   ctrl.cmd = CMD_RMUL;
            S_RACC:   ctrl.cmd = CMD_RACC;
            S_RFIN:   ctrl.cmd = CMD_RFIN;
            S_SCAN:
            begin
                if (!stat.scan_end)
                    ctrl.cmd = stat.scan_skip ? CMD_SCAN_NEXT : CMD_SCAN_RD;
            end
            S_DIF:    ctrl.cmd = CMD_DIF;
            S_SQX:    ctrl.cmd = CMD_SQX;
            S_SQY:    ctrl.cmd = CMD_SQY;
            S_SQR:    ctrl.cmd = CMD_SQR;
            S_CMP:
            begin
                if (!stat.hit)
                    ctrl.cmd = CMD_SCAN_NEXT;
            end
            S_FIN:
            begin
                if (stat.out_free)
                    ctrl.cmd = CMD_FINISH;
            end
            default:  ctrl.cmd = CMD_IDLE;
        endcase
    end

endmodule

// File: rtl/core/ncs_dpath.sv
module ncs_dpath #(
    parameter int MAX_CIRCLES = ncs_pkg::MAX_CIRCLES_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ncs_pkg::req_t     req,
    input  logic              rsp_stall,
    output ncs_pkg::rsp_t     rsp,
    output logic              rsp_valid,
    input  ncs_pkg::dp_ctrl_t ctrl,
    output ncs_pkg::dp_stat_t stat
);
    import ncs_pkg::*;

    localparam int NSLOT = (MAX_CIRCLES < SLOT_LIMIT) ? MAX_CIRCLES : SLOT_LIMIT;
    localparam int IW    = $clog2(NSLOT);
    localparam int CW    = IW + 1;

    // circle table
    logic signed [31:0] mem_x [NSLOT];
    logic signed [31:0] mem_y [NSLOT];
    logic [30:0]        mem_r [NSLOT];
    logic signed [31:0] rd_x_reg, rd_y_reg;
    logic [30:0]        rd_r_reg;
    logic               mem_we, mem_re;
    logic [IW-1:0]      rd_addr;

    // control registers
    logic [NSLOT-1:0] used_reg, used_next;
    logic             rsp_valid_reg, rsp_valid_next;
    logic [CW-1:0]    scan_reg, scan_next;
    logic [2:0]       k_reg, k_next;
    logic [3:0]       step_reg, step_next;
    logic [1:0]       midx_reg, midx_next;
    logic [IW-1:0]    tgt_reg, tgt_next;
    logic             skip_en_reg, skip_en_next;

    // payload registers
    req_t               item_reg, item_next;
    rsp_t               rsp_reg, rsp_next;
    logic signed [31:0] old_x_reg, old_x_next, old_y_reg, old_y_next;
    logic [30:0]        old_r_reg, old_r_next;
    logic signed [31:0] cand_x_reg, cand_x_next, cand_y_reg, cand_y_next;
    logic [30:0]        cand_r_reg, cand_r_next;
    logic [33:0]        m_reg, m_next;
    logic signed [25:0] z_reg, z_next;
    logic signed [31:0] cx_reg, cx_next, cy_reg, cy_next;
    logic               flip_reg, flip_next;
    logic signed [32:0] u_reg, u_next, v_reg, v_next;
    logic signed [65:0] p_reg, p_next, acc_reg, acc_next;
    logic [31:0]        ax_reg, ax_next, ay_reg, ay_next, rr_reg, rr_next;
    logic [63:0]        sx_reg, sx_next;
    logic [64:0]        sum_reg, sum_next;

    // helpers
    logic               is_create, rad_neg, slot_ok, free_found;
    logic [IW-1:0]      free_idx;
    logic signed [31:0] ox, oy, xs, ys;
    logic signed [32:0] c_val, s_val, mul_a, mul_b, dx, dy;
    logic signed [65:0] prod, rnd, shd;
    logic signed [25:0] ms, mh, atan_v;
    logic [33:0]        red_sub;
    logic signed [39:0] fin;

    assign is_create = (item_reg.opcode == OP_CREATE);
    assign rad_neg   = item_reg.radius_in[31];
    assign slot_ok   = ({1'b0, item_reg.slot} < 5'(NSLOT)) && used_reg[item_reg.slot[IW-1:0]];
    assign ox        = (item_reg.opcode == OP_ROT_PIVOT) ? item_reg.pos_x : 32'sd0;
    assign oy        = (item_reg.opcode == OP_ROT_PIVOT) ? item_reg.pos_y : 32'sd0;

    // first free slot
    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = NSLOT - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    // angle reduction and cordic terms
    assign red_sub = DEG_FULL << k_reg;
    assign ms      = signed'({1'b0, m_reg[24:0]});
    assign mh      = (ms > DEG_HALF_S) ? ms - DEG_FULL_S : ms;
    assign xs      = cx_reg >>> step_reg;
    assign ys      = cy_reg >>> step_reg;
    assign atan_v  = atan_deg(step_reg);
    assign c_val   = flip_reg ? -{cx_reg[31], cx_reg} : {cx_reg[31], cx_reg};
    assign s_val   = flip_reg ? -{cy_reg[31], cy_reg} : {cy_reg[31], cy_reg};

    // shared multiplier
    always_comb
    begin
        case (ctrl.cmd)
            CMD_SQX:
            begin
                mul_a = signed'({1'b0, ax_reg});
                mul_b = signed'({1'b0, ax_reg});
            end
            CMD_SQY:
            begin
                mul_a = signed'({1'b0, ay_reg});
                mul_b = signed'({1'b0, ay_reg});
            end
            CMD_SQR:
            begin
                mul_a = signed'({1'b0, rr_reg});
                mul_b = signed'({1'b0, rr_reg});
            end
            default:
            begin
                mul_a = midx_reg[0] ? v_reg : u_reg;
                mul_b = (midx_reg == 2'd0 || midx_reg == 2'd3) ? c_val : s_val;
            end
        endcase
    end
    assign prod = mul_a * mul_b;

    // rounding of rotated coordinate
    assign rnd = acc_reg + ROUND_HALF;
    assign shd = rnd >>> 28;
    assign fin = shd[39:0] + ((midx_reg == 2'd2) ? {{8{ox[31]}}, ox} : {{8{oy[31]}}, oy});

    // distance terms
    assign dx = {cand_x_reg[31], cand_x_reg} - {rd_x_reg[31], rd_x_reg};
    assign dy = {cand_y_reg[31], cand_y_reg} - {rd_y_reg[31], rd_y_reg};

    // table access
    assign mem_we  = (ctrl.cmd == CMD_FINISH) && (ctrl.kind == RES_COMMIT);
    assign mem_re  = (ctrl.cmd == CMD_RD_SLOT) || (ctrl.cmd == CMD_SCAN_RD);
    assign rd_addr = (ctrl.cmd == CMD_RD_SLOT) ? item_reg.slot[IW-1:0] : scan_reg[IW-1:0];

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_x[tgt_reg] <= cand_x_reg;
            mem_y[tgt_reg] <= cand_y_reg;
            mem_r[tgt_reg] <= cand_r_reg;
        end
        if (mem_re)
        begin
            rd_x_reg <= mem_x[rd_addr];
            rd_y_reg <= mem_y[rd_addr];
            rd_r_reg <= mem_r[rd_addr];
        end
    end

    // command execution
    always_comb
    begin
        item_next      = item_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        used_next      = used_reg;
        scan_next      = scan_reg;
        k_next         = k_reg;
        step_next      = step_reg;
        midx_next      = midx_reg;
        tgt_next       = tgt_reg;
        skip_en_next   = skip_en_reg;
        old_x_next     = old_x_reg;
        old_y_next     = old_y_reg;
        old_r_next     = old_r_reg;
        cand_x_next    = cand_x_reg;
        cand_y_next    = cand_y_reg;
        cand_r_next    = cand_r_reg;
        m_next         = m_reg;
        z_next         = z_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        flip_next      = flip_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        p_next         = p_reg;
        acc_next       = acc_reg;
        ax_next        = ax_reg;
        ay_next        = ay_reg;
        rr_next        = rr_reg;
        sx_next        = sx_reg;
        sum_next       = sum_reg;
        case (ctrl.cmd)
            CMD_LATCH:
                item_next = req;
            CMD_SET_CREATE:
            begin
                cand_x_next  = item_reg.pos_x;
                cand_y_next  = item_reg.pos_y;
                cand_r_next  = item_reg.radius_in[30:0];
                tgt_next     = free_idx;
                skip_en_next = 1'b0;
                scan_next    = '0;
            end
            CMD_LOAD_ENT:
            begin
                old_x_next   = rd_x_reg;
                old_y_next   = rd_y_reg;
                old_r_next   = rd_r_reg;
                cand_x_next  = rd_x_reg;
                cand_y_next  = rd_y_reg;
                cand_r_next  = rd_r_reg;
                tgt_next     = item_reg.slot[IW-1:0];
                skip_en_next = 1'b1;
                scan_next    = '0;
                m_next       = {{2{item_reg.angle_deg[31]}}, item_reg.angle_deg} + DEG_OFFSET;
                k_next       = 3'd7;
                case (item_reg.opcode)
                    OP_SET_CENTER:
                    begin
                        cand_x_next = item_reg.pos_x;
                        cand_y_next = item_reg.pos_y;
                    end
                    OP_SET_RADIUS:
                        cand_r_next = item_reg.radius_in[30:0];
                    OP_TRANSLATE:
                    begin
                        cand_x_next = sat32({{8{rd_x_reg[31]}}, rd_x_reg}
                                            + {{8{item_reg.pos_x[31]}}, item_reg.pos_x});
                        cand_y_next = sat32({{8{rd_y_reg[31]}}, rd_y_reg}
                                            + {{8{item_reg.pos_y[31]}}, item_reg.pos_y});
                    end
                    default:
                        cand_r_next = rd_r_reg;
                endcase
            end
            CMD_RED:
            begin
                if (m_reg >= red_sub)
                    m_next = m_reg - red_sub;
                k_next = k_reg - 3'd1;
            end
            CMD_FOLD:
            begin
                if (mh > DEG_QUARTER_S)
                begin
                    z_next    = mh - DEG_HALF_S;
                    flip_next = 1'b1;
                end
                else if (mh < -DEG_QUARTER_S)
                begin
                    z_next    = mh + DEG_HALF_S;
                    flip_next = 1'b1;
                end
                else
                begin
                    z_next    = mh;
                    flip_next = 1'b0;
                end
                cx_next   = CORDIC_K_Q28;
                cy_next   = 32'sd0;
                step_next = 4'd0;
                midx_next = 2'd0;
                u_next    = {cand_x_reg[31], cand_x_reg} - {ox[31], ox};
                v_next    = {cand_y_reg[31], cand_y_reg} - {oy[31], oy};
            end
            CMD_CORDIC:
            begin
                if (z_reg >= 26'sd0)
                begin
                    cx_next = cx_reg - ys;
                    cy_next = cy_reg + xs;
                    z_next  = z_reg - atan_v;
                end
                else
                begin
                    cx_next = cx_reg + ys;
                    cy_next = cy_reg - xs;
                    z_next  = z_reg + atan_v;
                end
                step_next = step_reg + 4'd1;
            end
            CMD_RMUL:
                p_next = prod;
            CMD_RACC:
            begin
                case (midx_reg)
                    2'd1:    acc_next = acc_reg - p_reg;
                    2'd3:    acc_next = acc_reg + p_reg;
                    default: acc_next = p_reg;
                endcase
                midx_next = midx_reg + 2'd1;
            end
            CMD_RFIN:
            begin
                if (midx_reg == 2'd2)
                    cand_x_next = sat32(fin);
                else
                    cand_y_next = sat32(fin);
            end
            CMD_SCAN_NEXT:
                scan_next = scan_reg + CW'(1);
            CMD_DIF:
            begin
                ax_next = dx[32] ? 32'(-dx) : dx[31:0];
                ay_next = dy[32] ? 32'(-dy) : dy[31:0];
                rr_next = {1'b0, cand_r_reg} + {1'b0, rd_r_reg};
            end
            CMD_SQX:
                p_next = prod;
            CMD_SQY:
            begin
                p_next  = prod;
                sx_next = p_reg[63:0];
            end
            CMD_SQR:
            begin
                p_next   = prod;
                sum_next = {1'b0, sx_reg} + {1'b0, p_reg[63:0]};
            end
            CMD_FINISH:
            begin
                rsp_valid_next        = 1'b1;
                rsp_next.slot_out     = 4'(tgt_reg);
                rsp_next.center_x_out = old_x_reg;
                rsp_next.center_y_out = old_y_reg;
                rsp_next.radius_out   = old_r_reg;
                case (ctrl.kind)
                    RES_NEG:     rsp_next.status = STAT_NEG_RADIUS;
                    RES_FULL:    rsp_next.status = STAT_FULL;
                    RES_OVERLAP: rsp_next.status = STAT_OVERLAP;
                    RES_EMPTY:   rsp_next.status = STAT_EMPTY;
                    default:     rsp_next.status = STAT_OK;
                endcase
                // failed create reports a status but no slot or circle
                if (is_create && ctrl.kind != RES_COMMIT)
                begin
                    rsp_next.slot_out     = 4'd0;
                    rsp_next.center_x_out = 32'sd0;
                    rsp_next.center_y_out = 32'sd0;
                    rsp_next.radius_out   = 31'd0;
                end
                if (ctrl.kind == RES_EMPTY || ctrl.kind == RES_REMOVE)
                begin
                    rsp_next.slot_out     = item_reg.slot;
                    rsp_next.center_x_out = 32'sd0;
                    rsp_next.center_y_out = 32'sd0;
                    rsp_next.radius_out   = 31'd0;
                end
                if (ctrl.kind == RES_REMOVE)
                    used_next[tgt_reg] = 1'b0;
                if (ctrl.kind == RES_COMMIT)
                begin
                    rsp_next.center_x_out = cand_x_reg;
                    rsp_next.center_y_out = cand_y_reg;
                    rsp_next.radius_out   = cand_r_reg;
                    used_next[tgt_reg]    = 1'b1;
                end
            end
            default:
                rsp_valid_next = rsp_valid_reg && rsp_stall;
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= '0;
            rsp_valid_reg <= 1'b0;
            scan_reg      <= '0;
            k_reg         <= '0;
            step_reg      <= '0;
            midx_reg      <= '0;
            tgt_reg       <= '0;
            skip_en_reg   <= 1'b0;
        end
        else
        begin
            used_reg      <= used_next;
            rsp_valid_reg <= rsp_valid_next;
            scan_reg      <= scan_next;
            k_reg         <= k_next;
            step_reg      <= step_next;
            midx_reg      <= midx_next;
            tgt_reg       <= tgt_next;
            skip_en_reg   <= skip_en_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        rsp_reg    <= rsp_next;
        old_x_reg  <= old_x_next;
        old_y_reg  <= old_y_next;
        old_r_reg  <= old_r_next;
        cand_x_reg <= cand_x_next;
        cand_y_reg <= cand_y_next;
        cand_r_reg <= cand_r_next;
        m_reg      <= m_next;
        z_reg      <= z_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        flip_reg   <= flip_next;
        u_reg      <= u_next;
        v_reg      <= v_next;
        p_reg      <= p_next;
        acc_reg    <= acc_next;
        ax_reg     <= ax_next;
        ay_reg     <= ay_next;
        rr_reg     <= rr_next;
        sx_reg     <= sx_next;
        sum_reg    <= sum_next;
    end

    // status to controller
    always_comb
    begin
        stat.op          = item_reg.opcode;
        stat.rad_neg     = rad_neg;
        stat.free_found  = free_found;
        stat.slot_ok     = slot_ok;
        stat.red_last    = (k_reg == 3'd0);
        stat.cordic_last = (step_reg == CORDIC_LAST);
        stat.racc_fin    = midx_reg[0];
        stat.rot_done    = (midx_reg == 2'd0);
        stat.scan_end    = (scan_reg == CW'(NSLOT));
        stat.scan_skip   = !used_reg[scan_reg[IW-1:0]]
                           || (skip_en_reg && scan_reg[IW-1:0] == tgt_reg);
        stat.hit         = !sum_reg[64] && (sum_reg[63:0] <= p_reg[63:0]);
        stat.out_free    = !rsp_valid_reg || !rsp_stall;
    end

    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

endmodule

// File: rtl/core/nonoverlapping_circle_set.sv
// after acceptance, a negative-radius create, a full table or an empty slot end at decode;
// remove, unused opcode or negative set radius at load; create scans from decode, other
// changes from load; the scan skips free or own entries and checks each stored circle
// by difference, squares and compare, a hit ending it early; rotations add angle
// reduction and cordic steps; one transaction at a time, next accepted after the result
// reset: slot table emptied and response channel idle at once, no clearing pass
module nonoverlapping_circle_set #(
    parameter int MAX_CIRCLES = ncs_pkg::MAX_CIRCLES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  ncs_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output ncs_pkg::rsp_t rsp
);
    import ncs_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    // sequencer
    ncs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    // table, cordic and overlap datapath
    ncs_dpath #(
        .MAX_CIRCLES (MAX_CIRCLES)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .rsp_valid (rsp_valid),
        .ctrl      (ctrl),
        .stat      (stat)
    );

endmodule

// File: rtl/core/ncs_checker.sv
module ncs_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_stall,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input ncs_pkg::rsp_t rsp
);
    import ncs_pkg::*;

    // one transaction in flight
    a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request accepted while busy");

    // held response
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled response changed");

    // legal status
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == STAT_OK || rsp.status == STAT_OVERLAP
            || rsp.status == STAT_NEG_RADIUS || rsp.status == STAT_FULL
            || rsp.status == STAT_EMPTY)
        else $error("bad status code");

    // empty or full reports carry no circle
    a_no_circle: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status == STAT_EMPTY || rsp.status == STAT_FULL)
            |-> rsp.center_x_out == 0 && rsp.center_y_out == 0 && rsp.radius_out == 0)
        else $error("circle reported with empty or full status");

    // table full reports slot zero
    a_full_slot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.status == STAT_FULL |-> rsp.slot_out == 0)
        else $error("full status with nonzero slot");

endmodule

bind nonoverlapping_circle_set ncs_checker u_ncs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// File: dv/circle_set_checker.sv
module circle_set_checker (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  ncs_pkg::req_t  req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  ncs_pkg::rsp_t  rsp,
    output int             fail_count,
    output int             pending
);
    import ncs_pkg::*;

    localparam int NSLOT = MAX_CIRCLES_DEF;

    // shadow copy of the circle table
    logic signed [31:0] cx_tab [NSLOT];
    logic signed [31:0] cy_tab [NSLOT];
    logic [30:0]        rad_tab [NSLOT];
    logic               used_tab [NSLOT];

    rsp_t expected_rsp_q[$];

    assign pending = expected_rsp_q.size();

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint atan_q16(input int i);
        longint t [16] = '{2949120, 1740967, 919879, 466945, 234379, 117305, 58666,
                           29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};
        return t[i];
    endfunction

    // >>> on longint floors for negatives
    function automatic void cordic_sincos(input longint ang, output longint c,
                                          output longint s);
        longint m, x, y, z, xs, ys;
        bit flip;
        m = ang % 64'sd23592960;
        x = 64'sd163008219;
        y = 0;
        flip = 0;
        if (m < 0)
            m += 64'sd23592960;
        if (m > 64'sd11796480)
            m -= 64'sd23592960;
        if (m > 64'sd5898240)
        begin
            m -= 64'sd11796480;
            flip = 1;
        end
        else if (m < -64'sd5898240)
        begin
            m += 64'sd11796480;
            flip = 1;
        end
        z = m;
        for (int i = 0; i < 16; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x -= ys;
                y += xs;
                z -= atan_q16(i);
            end
            else
            begin
                x += ys;
                y -= xs;
                z += atan_q16(i);
            end
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endfunction

    // touching counts as overlap; sums that wrap 64 bits are skipped
    function automatic bit hits_other(input int skip, input longint x, input longint y,
                                      input longint r);
        longint unsigned ax, ay, sx, sum, rr;
        longint dx, dy;
        for (int i = 0; i < NSLOT; i++)
        begin
            if (!used_tab[i] || i == skip)
                continue;
            dx = x - longint'(cx_tab[i]);
            dy = y - longint'(cy_tab[i]);
            ax = dx < 0 ? -dx : dx;
            ay = dy < 0 ? -dy : dy;
            sx = ax * ax;
            sum = sx + ay * ay;
            if (sum < sx)
                continue;
            rr = r + longint'(rad_tab[i]);
            if (sum <= rr * rr)
                return 1;
        end
        return 0;
    endfunction

    function automatic rsp_t make_rsp(input logic [2:0] st, input int sl, input longint x,
                                      input longint y, input longint r);
        rsp_t o;
        o.status = st;
        o.slot_out = sl[3:0];
        o.center_x_out = x[31:0];
        o.center_y_out = y[31:0];
        o.radius_out = r[30:0];
        return o;
    endfunction

    // compute response and update the table
    function automatic rsp_t apply_request(input req_t t);
        longint px, py, rd, nx, ny, nr, c, s, u, v, ox, oy;
        int sl, fs;
        px = longint'(t.pos_x);
        py = longint'(t.pos_y);
        rd = longint'(t.radius_in);
        sl = t.slot;
        if (t.opcode == OP_CREATE)
        begin
            if (rd < 0)
                return make_rsp(STAT_NEG_RADIUS, 0, 0, 0, 0);
            fs = -1;
            for (int i = NSLOT - 1; i >= 0; i--)
                if (!used_tab[i])
                    fs = i;
            if (fs < 0)
                return make_rsp(STAT_FULL, 0, 0, 0, 0);
            if (hits_other(NSLOT, px, py, rd))
                return make_rsp(STAT_OVERLAP, 0, 0, 0, 0);
            cx_tab[fs] = px[31:0];
            cy_tab[fs] = py[31:0];
            rad_tab[fs] = rd[30:0];
            used_tab[fs] = 1;
            return make_rsp(STAT_OK, fs, px, py, rd);
        end
        if (!used_tab[sl])
            return make_rsp(STAT_EMPTY, sl, 0, 0, 0);
        nx = cx_tab[sl];
        ny = cy_tab[sl];
        nr = rad_tab[sl];
        case (t.opcode)
            OP_SET_CENTER:
            begin
                nx = px;
                ny = py;
            end
            OP_SET_RADIUS:
            begin
                if (rd < 0)
                    return make_rsp(STAT_NEG_RADIUS, sl, nx, ny, nr);
                nr = rd;
            end
            OP_TRANSLATE:
            begin
                nx = clamp32(nx + px);
                ny = clamp32(ny + py);
            end
            OP_ROT_ORIGIN, OP_ROT_PIVOT:
            begin
                ox = (t.opcode == OP_ROT_PIVOT) ? px : 0;
                oy = (t.opcode == OP_ROT_PIVOT) ? py : 0;
                cordic_sincos(longint'(t.angle_deg), c, s);
                u = nx - ox;
                v = ny - oy;
                nx = clamp32(ox + ((u * c - v * s + (64'sd1 << 27)) >>> 28));
                ny = clamp32(oy + ((u * s + v * c + (64'sd1 << 27)) >>> 28));
            end
            OP_REMOVE:
            begin
                used_tab[sl] = 0;
                return make_rsp(STAT_OK, sl, 0, 0, 0);
            end
            default:
                return make_rsp(STAT_OK, sl, nx, ny, nr);
        endcase
        if (hits_other(sl, nx, ny, nr))
            return make_rsp(STAT_OVERLAP, sl, cx_tab[sl], cy_tab[sl], rad_tab[sl]);
        cx_tab[sl] = nx[31:0];
        cy_tab[sl] = ny[31:0];
        rad_tab[sl] = nr[30:0];
        return make_rsp(STAT_OK, sl, nx, ny, nr);
    endfunction

    // watch both channels
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t e;
        if (!rst_n)
        begin
            fail_count <= 0;
            expected_rsp_q.delete();
            for (int i = 0; i < NSLOT; i++)
                used_tab[i] = 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    $error("response transaction with nothing expected");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    e = expected_rsp_q.pop_front();
                    if (rsp.status !== e.status)
                        $error("status exp %0d got %0d", e.status, rsp.status);
                    if (rsp.slot_out !== e.slot_out)
                        $error("slot_out exp %0d got %0d", e.slot_out, rsp.slot_out);
                    if (rsp.center_x_out !== e.center_x_out)
                        $error("center_x_out exp %0d got %0d", e.center_x_out,
                               rsp.center_x_out);
                    if (rsp.center_y_out !== e.center_y_out)
                        $error("center_y_out exp %0d got %0d", e.center_y_out,
                               rsp.center_y_out);
                    if (rsp.radius_out !== e.radius_out)
                        $error("radius_out exp %0d got %0d", e.radius_out, rsp.radius_out);
                    if (rsp !== e)
                        fail_count <= fail_count + 1;
                end
            end
            if (req_valid && !req_stall)
                expected_rsp_q.insert(expected_rsp_q.size(), apply_request(req));
        end
    end

endmodule

// File: dv/tb_nonoverlapping_circle_set.sv
module tb_nonoverlapping_circle_set;
    import ncs_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    int   fail_count;
    int   pending;
    int   idle_cycles = 0;

    localparam int IDLE_LIMIT = 20000;
    localparam int Q16 = 65536;

    nonoverlapping_circle_set dut (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
    );

    circle_set_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_stall(req_stall), .req(req),
        .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
        .fail_count(fail_count), .pending(pending)
    );

    initial
        clk = 0;
    always
    begin
        #1 clk = 1;
        #1 clk = 0;
    end

    // mostly short gaps, some long
    function automatic int gap_len();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // response stall pattern
    initial
    begin
        int g;
        rsp_stall = 0;
        @(posedge rst_n);
        forever
        begin
            g = gap_len();
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (g > 0)
            begin
                rsp_stall <= 1;
                repeat (g) @(posedge clk);
                rsp_stall <= 0;
            end
        end
    end

    // stall watchdog
    always @(posedge clk)
    begin
        if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_transaction(input req_t t);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req_valid <= 0;
            repeat (g) @(posedge clk);
        end
        req <= t;
        req_valid <= 1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    function automatic req_t mk(input logic [2:0] op, input logic [3:0] sl,
                                input int x, input int y, input int r, input int a);
        req_t t;
        t.opcode = op;
        t.slot = sl;
        t.pos_x = x;
        t.pos_y = y;
        t.radius_in = r;
        t.angle_deg = a;
        return t;
    endfunction

    // random coordinate: mostly modest, sometimes full range
    function automatic int rnd_coord();
        if ($urandom_range(0, 9) == 0)
            return int'($urandom);
        return $urandom_range(0, 400 * Q16) - 200 * Q16;
    endfunction

    function automatic req_t rnd_req();
        req_t t;
        int p;
        t = mk(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)), rnd_coord(),
               rnd_coord(), $urandom_range(0, 8 * Q16), int'($urandom));
        p = $urandom_range(0, 99);
        if (p < 25)
            t.opcode = OP_CREATE;
        else if (p < 30)
            t.opcode = OP_REMOVE;
        if ($urandom_range(0, 19) == 0)
            t.radius_in = int'($urandom);
        if ($urandom_range(0, 3) == 0)
            t.angle_deg = $urandom_range(0, 720 * Q16) - 360 * Q16;
        if ($urandom_range(0, 7) == 0)
            t.pos_x = $urandom_range(0, 20 * Q16) - 10 * Q16;
        return t;
    endfunction

    initial
    begin
        int lim;
        rst_n = 0;
        req_valid = 0;
        req = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: empty table, extremes, every opcode, touching, saturation
        send_transaction(mk(OP_SET_CENTER, 4'd15, 0, 0, 0, 0));
        send_transaction(mk(OP_CREATE, 0, 0, 0, -1, 0));
        send_transaction(mk(OP_CREATE, 0, 0, 0, Q16, 0));
        send_transaction(mk(OP_CREATE, 0, 2 * Q16, 0, Q16, 0));
        send_transaction(mk(OP_CREATE, 0, 3 * Q16, 0, Q16, 0));
        send_transaction(mk(OP_SET_RADIUS, 4'd1, 0, 0, -32'sd2147483648, 0));
        send_transaction(mk(OP_SET_RADIUS, 4'd1, 0, 0, 3 * Q16, 0));
        send_transaction(mk(OP_TRANSLATE, 4'd1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 0, 0));
        send_transaction(mk(OP_TRANSLATE, 4'd1, 32'sh80000000, 32'sh80000000, 0, 0));
        send_transaction(mk(OP_SET_CENTER, 4'd1, 32'sh7FFF0000, 32'sh80000000, 0, 0));
        send_transaction(mk(OP_ROT_ORIGIN, 4'd1, 0, 0, 0, 90 * Q16));
        send_transaction(mk(OP_ROT_ORIGIN, 4'd0, 0, 0, 0, 180 * Q16));
        send_transaction(mk(OP_ROT_ORIGIN, 4'd1, 0, 0, 0, 32'sh80000000));
        send_transaction(mk(OP_ROT_PIVOT, 4'd1, 32'sh7FFFFFFF, -5, 0, 32'sh7FFFFFFF));
        send_transaction(mk(OP_ROT_PIVOT, 4'd1, Q16, Q16, 0, -270 * Q16));
        send_transaction(mk(3'd7, 4'd1, 0, 0, 0, 0));
        send_transaction(mk(3'd7, 4'd9, 0, 0, 0, 0));
        send_transaction(mk(OP_CREATE, 0, 32'sh80000000, 32'sh7FFFFFFF,
                            32'sh7FFFFFFF, 0));
        send_transaction(mk(OP_REMOVE, 4'd0, 0, 0, 0, 0));
        send_transaction(mk(OP_REMOVE, 4'd0, 0, 0, 0, 0));
        // fill the table to hit the full case
        for (int i = 0; i < 17; i++)
            send_transaction(mk(OP_CREATE, 0, i * 10 * Q16, -50 * Q16, Q16, 0));
        for (int i = 0; i < 16; i++)
            send_transaction(mk(OP_REMOVE, 4'(i), 0, 0, 0, 0));

        // random phase
        for (int n = 0; n < 1560; n++)
            send_transaction(rnd_req());
        req_valid <= 0;

        // drain
        lim = 0;
        while (pending != 0 && lim < 100000)
        begin
            @(posedge clk);
            lim++;
        end
        repeat (200) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

// File: nonoverlapping_circle_set.f
rtl/core/ncs_pkg.sv
rtl/core/ncs_ctrl.sv
rtl/core/ncs_dpath.sv
rtl/core/nonoverlapping_circle_set.sv
rtl/core/ncs_checker.sv
dv/circle_set_checker.sv
dv/tb_nonoverlapping_circle_set.sv
